>>> rtl/rbt_pkg.sv
// Shared widths and defaults for the finish-time ranking block.
`timescale 1ns / 1ps
package rbt_pkg;

  localparam int unsigned TIME_W      = 20;
  localparam int unsigned ENTRY_W     = 6;
  localparam int unsigned PLACE_W     = 7;
  localparam int unsigned DEF_ENTRIES = 8;

endpackage

>>> rtl/rbt_store.sv
// Time store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module rbt_store #(
  parameter int unsigned ENTRIES = rbt_pkg::DEF_ENTRIES
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(ENTRIES)-1:0]          waddr_i,
  input  logic [rbt_pkg::TIME_W-1:0]          wdata_i,
  input  logic [$clog2(ENTRIES)-1:0]          raddr_i,
  output logic [rbt_pkg::TIME_W-1:0]          rdata_o
);
  import rbt_pkg::*;

  logic [TIME_W-1:0] mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/rank_by_time.sv
// Top level: collects a batch of finish times and ranks them in place order.
//
// Input: a request is taken when start_i is high and busy_o is low; it
// carries one finish time (hundredths of a second). ENTRIES requests form
// one batch, loaded one per cycle into the time store.
// After the last request of a batch busy_o rises and the block ranks the
// batch: for each entry in load order it reads that entry's time, then
// reads every stored time through the single store read port and counts
// the faster ones (equal times of later entries count as faster).
// One result per entry appears in index order on valid_o, entry_index_o,
// place_o and final_result_o for exactly one cycle; final_result_o marks
// the last entry. busy_o falls in the cycle that shows the last result.
// No new request is taken while a batch is being ranked.
// The receiver cannot stall: results are shown once and never held.
// Reset returns to loading at entry 0; the store contents are undefined
// until written and need no clearing.
`timescale 1ns / 1ps
module rank_by_time #(
  parameter int unsigned ENTRIES = rbt_pkg::DEF_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rbt_pkg::TIME_W-1:0]    finish_time_i,
  output logic                          busy_o,
  output logic                          valid_o,
  output logic [rbt_pkg::ENTRY_W-1:0]   entry_index_o,
  output logic [rbt_pkg::PLACE_W-1:0]   place_o,
  output logic                          final_result_o
);
  import rbt_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_FETCH,
    S_PIVOT,
    S_SCAN
  } state_e;

  state_e               state_q;
  logic [IDX_W-1:0]     load_q;
  logic [IDX_W-1:0]     i_q;
  logic [IDX_W-1:0]     jd_q;
  logic [IDX_W-1:0]     jn_q;
  logic [PLACE_W-1:0]   cnt_q;
  logic [TIME_W-1:0]    pivot_q;
  logic                 valid_q;
  logic [ENTRY_W-1:0]   entry_q;
  logic [PLACE_W-1:0]   place_q;
  logic                 final_q;

  logic                 accept;
  logic [IDX_W-1:0]     rd_addr;
  logic [TIME_W-1:0]    rd_data;
  logic                 faster;
  logic [PLACE_W-1:0]   place_sum;

  assign accept = start_i && (state_q == S_LOAD);

  rbt_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (load_q),
    .wdata_i (finish_time_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    unique case (state_q)
      S_FETCH: rd_addr = i_q;
      S_PIVOT: rd_addr = '0;
      S_SCAN:  rd_addr = jn_q;
      default: rd_addr = i_q;
    endcase
  end

  assign faster    = (rd_data < pivot_q) || ((rd_data == pivot_q) && (jd_q > i_q));
  assign place_sum = cnt_q + PLACE_W'(faster);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      load_q  <= '0;
      i_q     <= '0;
      jd_q    <= '0;
      jn_q    <= '0;
      cnt_q   <= '0;
      pivot_q <= '0;
      valid_q <= 1'b0;
      entry_q <= '0;
      place_q <= '0;
      final_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (start_i) begin
            if (load_q == LAST) begin
              load_q  <= '0;
              i_q     <= '0;
              state_q <= S_FETCH;
            end else begin
              load_q <= load_q + ONE;
            end
          end
        end
        S_FETCH: begin
          state_q <= S_PIVOT;
        end
        S_PIVOT: begin
          pivot_q <= rd_data;
          jd_q    <= '0;
          jn_q    <= ONE;
          cnt_q   <= PLACE_W'(1);
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          cnt_q <= place_sum;
          jd_q  <= jn_q;
          if (jn_q != LAST) begin
            jn_q <= jn_q + ONE;
          end
          if (jd_q == LAST) begin
            valid_q <= 1'b1;
            entry_q <= ENTRY_W'(i_q);
            place_q <= place_sum;
            final_q <= (i_q == LAST);
            if (i_q == LAST) begin
              state_q <= S_LOAD;
            end else begin
              i_q     <= i_q + ONE;
              state_q <= S_FETCH;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign busy_o         = (state_q != S_LOAD);
  assign valid_o        = valid_q;
  assign entry_index_o  = entry_q;
  assign place_o        = place_q;
  assign final_result_o = final_q;

  a_last_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (load_q == LAST)) |=> busy_o)
    else $error("busy not raised after last load");

  a_place_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((place_o != '0) && (place_o <= PLACE_W'(ENTRIES))))
    else $error("place out of range");

  a_final_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && final_result_o) |-> (entry_index_o == ENTRY_W'(ENTRIES - 1)))
    else $error("final result on wrong entry");

  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("back-to-back results");

endmodule

>>> bench/tb_rank_by_time.sv
// Self-checking bench for rank_by_time: feeds batches of finish times, predicts the places.
`timescale 1ns / 1ps
module tb_rank_by_time;
  import rbt_pkg::*;

  localparam int unsigned ENTRIES        = DEF_ENTRIES;
  localparam int unsigned RANK_CYCLES    = ENTRIES * (ENTRIES + 2);
  localparam int unsigned RANDOM_BATCHES = 40;

  typedef struct packed {
    logic [TIME_W-1:0] fin;
    logic              drain_first;
  } feed_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic [PLACE_W-1:0] place;
    logic               last;
  } placing_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start_i       = 1'b0;
  logic [TIME_W-1:0]  finish_time_i = '0;
  logic               busy_o;
  logic               valid_o;
  logic [ENTRY_W-1:0] entry_index_o;
  logic [PLACE_W-1:0] place_o;
  logic               final_result_o;

  feed_t             time_feed[$];
  placing_t          places_due[$];
  logic [TIME_W-1:0] times_held [ENTRIES];
  int unsigned       loaded_cnt = 0;
  int unsigned       fail_cnt   = 0;
  int unsigned       burst_left = 0;
  int unsigned       gap_left   = 0;
  bit                offered    = 1'b0;
  bit                taken      = 1'b0;

  rank_by_time #(.ENTRIES(ENTRIES)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .finish_time_i  (finish_time_i),
    .busy_o         (busy_o),
    .valid_o        (valid_o),
    .entry_index_o  (entry_index_o),
    .place_o        (place_o),
    .final_result_o (final_result_o)
  );

  always #5 clk_i = ~clk_i;

  // Hand out places from slowest to fastest; on ties the earlier entry goes first.
  function automatic void rank_batch();
    logic [PLACE_W-1:0] placed [ENTRIES];
    logic [TIME_W-1:0]  slowest;
    int unsigned        pick;
    bit                 found;
    for (int i = 0; i < ENTRIES; i++) placed[i] = '0;
    for (int r = ENTRIES; r > 0; r--) begin
      found   = 1'b0;
      pick    = 0;
      slowest = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (placed[i] == '0 && (!found || times_held[i] > slowest)) begin
          found   = 1'b1;
          slowest = times_held[i];
          pick    = i;
        end
      end
      placed[pick] = PLACE_W'(r);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      places_due.push_back('{ENTRY_W'(i), placed[i], (i == ENTRIES - 1)});
    end
  endfunction

  function automatic void store_time(logic [TIME_W-1:0] t);
    times_held[loaded_cnt] = t;
    if (loaded_cnt == ENTRIES - 1) begin
      loaded_cnt = 0;
      rank_batch();
    end else begin
      loaded_cnt++;
    end
  endfunction

  function automatic void queue_time(logic [TIME_W-1:0] t, bit drain);
    time_feed.push_back('{t, drain});
  endfunction

  always @(posedge clk_i) begin
    placing_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        store_time(finish_time_i);
        taken = 1'b1;
      end
      if (valid_o === 1'b1) begin
        if (places_due.size() == 0) begin
          $display("%0t: unexpected result entry %0d place %0d last %0b",
                   $time, entry_index_o, place_o, final_result_o);
          fail_cnt++;
        end else begin
          want = places_due.pop_front();
          if (entry_index_o !== want.idx) begin
            $display("%0t: entry_index expected %0d actual %0d", $time, want.idx, entry_index_o);
            fail_cnt++;
          end
          if (place_o !== want.place) begin
            $display("%0t: place of entry %0d expected %0d actual %0d",
                     $time, want.idx, want.place, place_o);
            fail_cnt++;
          end
          if (final_result_o !== want.last) begin
            $display("%0t: final_result of entry %0d expected %0b actual %0b",
                     $time, want.idx, want.last, final_result_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    feed_t nxt;
    if (rst_ni) begin
      if (taken) begin
        offered = 1'b0;
        taken   = 1'b0;
      end
      if (!offered) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (time_feed.size() > 0 &&
                     !(time_feed[0].drain_first && places_due.size() > 0)) begin
          nxt = time_feed.pop_front();
          finish_time_i <= nxt.fin;
          offered = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 10);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      start_i <= offered;
    end
  end

  initial begin
    logic [TIME_W-1:0] corner_times [ENTRIES];
    logic [TIME_W-1:0] base;
    int unsigned       mode;
    logic [TIME_W-1:0] t;
    corner_times = '{20'hFFFFF, 20'h00001, 20'h80000, 20'h7FFFF,
                     20'h00000, 20'hFFFFE, 20'h00001, 20'hFFFFF};
    for (int i = 0; i < ENTRIES; i++) queue_time('0, 1'b0);
    for (int i = 0; i < ENTRIES; i++) queue_time((i % 2) ? '1 : '0, 1'b0);
    for (int i = 0; i < ENTRIES; i++) queue_time(corner_times[i], 1'b0);
    for (int b = 0; b < RANDOM_BATCHES; b++) begin
      mode = $urandom_range(0, 3);
      base = TIME_W'($urandom);
      for (int i = 0; i < ENTRIES; i++) begin
        case (mode)
          0: t = TIME_W'($urandom);
          1: t = TIME_W'($urandom_range(0, 3));
          2: t = $urandom_range(0, 1) ? '1 : '0;
          default: t = base + TIME_W'($urandom_range(0, 4));
        endcase
        queue_time(t, (i == 0) && (b % 7 == 3));
      end
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (time_feed.size() > 0 || offered || places_due.size() > 0) @(posedge clk_i);
    repeat (RANK_CYCLES + 20) @(posedge clk_i);
    if (fail_cnt == 0 && places_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
